>>> rtl/core/assert_macros.svh
// Assertion macros shared by the blur core modules.
// Each user module must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define BBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define BBC_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/bbc_pkg.sv
// Shared types and constants of the box blur core.
// No dependencies; imported by every core module but bbc_fifo.
`default_nettype none
package bbc_pkg;

  localparam int ROW_W = 10;
  localparam int WS_W = 4;
  localparam int RAD_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd2;

  localparam logic [9:0] FRAME_WIDTH_RST = 10'd512;
  localparam logic [9:0] FRAME_HEIGHT_RST = 10'd512;
  localparam logic [WS_W-1:0] WINDOW_SIZE_RST = 4'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_end;
    logic       frame_end;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/bbc_fifo.sv
// Small synchronous queue used for the job and result paths.
// Depends on nothing but its parameters.
`default_nettype none
module bbc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/bbc_store.sv
// Line store of the blur core: one write port, one registered read port.
// Holds the raw input pixels; uses bbc_pkg for the pixel type.
`default_nettype none
module bbc_store #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                                          clk,
  input  wire logic                                          wr_en,
  input  wire logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0]       wr_addr,
  input  wire bbc_pkg::pixel_t                               wr_data,
  input  wire logic                                          rd_en,
  input  wire logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0]       rd_addr,
  output bbc_pkg::pixel_t                                    rd_data
);
  import bbc_pkg::*;
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/bbc_front.sv
// Front end: configuration registers, raster counters, line store writes
// and the decision which input word releases an output job. Uses bbc_pkg.
`default_nettype none
`include "assert_macros.svh"
module bbc_front #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    push,
  output logic                                         full,
  input  wire logic                                    operation,
  input  wire bbc_pkg::pixel_t                         pix,
  input  wire logic                                    cfg_write,
  input  wire logic [bbc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [bbc_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  wire logic                                    job_empty,
  input  wire logic                                    back_busy,
  output logic                                         job_push,
  output logic [bbc_pkg::ROW_W-1:0]                    job_row,
  output logic [$clog2(MAX_WIDTH)-1:0]                 job_col,
  output logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0]      job_addr,
  output logic                                         job_line_end,
  output logic                                         job_frame_end,
  output logic                                         wr_en,
  output logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0]      wr_addr,
  output bbc_pkg::pixel_t                              wr_data,
  output logic [$clog2(MAX_WIDTH+1)-1:0]               geo_w,
  output logic [bbc_pkg::ROW_W-1:0]                    geo_h,
  output logic [bbc_pkg::WS_W-1:0]                     geo_ws,
  output logic [bbc_pkg::RAD_W-1:0]                    geo_rad
);
  import bbc_pkg::*;
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int GAP_W = ROW_W + WW;
  localparam int LAG_W = WW + RAD_W + 1;
  localparam int RAD_MAX = (MAX_WINDOW - 1) / 2;

  logic [9:0] frame_width;
  logic [9:0] frame_height;
  logic [WS_W-1:0] window_size;

  logic [COL_W-1:0] in_col, in_col_next, out_col, out_col_next;
  logic [ROW_W-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [AW-1:0] in_addr, in_addr_next, out_addr, out_addr_next;
  logic [GAP_W-1:0] gap, gap_next, gap_w;

  logic accept, cfg_hit, in_last_col, out_last_col, frame_done;
  logic [WS_W-1:0] ws_clip;
  logic [RAD_W-1:0] rad_raw;
  logic [LAG_W-1:0] lag;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    logic [AW:0] s;
    s = {1'b0, a} + (AW+1)'(1);
    return (s == (AW+1)'(DEPTH)) ? '0 : s[AW-1:0];
  endfunction

  // Effective geometry: zero acts as one, oversize width and window values clamp.
  always_comb begin
    if (frame_width == '0) begin
      geo_w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      geo_w = WW'(MAX_WIDTH);
    end else begin
      geo_w = WW'(frame_width);
    end
    geo_h = (frame_height == '0) ? ROW_W'(1) : frame_height;
    if (window_size == '0) begin
      ws_clip = WS_W'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      ws_clip = WS_W'(MAX_WINDOW);
    end else begin
      ws_clip = window_size;
    end
    geo_ws = ws_clip;
    rad_raw = RAD_W'(ws_clip >> 1);
    geo_rad = (32'(rad_raw) > RAD_MAX) ? RAD_W'(RAD_MAX) : rad_raw;
  end

  assign lag = LAG_W'(geo_rad) * LAG_W'(geo_w) + LAG_W'(geo_rad);
  assign full = !job_empty || back_busy;
  assign accept = push && !full;
  assign cfg_hit = cfg_write && (cfg_index == REG_FRAME_WIDTH ||
                                 cfg_index == REG_FRAME_HEIGHT ||
                                 cfg_index == REG_WINDOW_SIZE);

  assign wr_en = accept && (operation == OP_PIXEL) && (in_row < geo_h);
  assign wr_addr = in_addr;
  assign wr_data = pix;

  assign in_last_col = (WW'(in_col) + WW'(1) == geo_w);
  assign out_last_col = (WW'(out_col) + WW'(1) == geo_w);

  always_comb begin
    in_col_next = in_col;
    in_row_next = in_row;
    in_addr_next = in_addr;
    if (wr_en) begin
      in_addr_next = addr_inc(in_addr);
      if (in_last_col) begin
        in_col_next = '0;
        in_row_next = in_row + ROW_W'(1);
      end else begin
        in_col_next = in_col + COL_W'(1);
      end
    end
    gap_w = gap + GAP_W'(wr_en);
    // An output is due once the input is far enough ahead, or the frame
    // input is complete and only draining remains.
    job_push = accept && (out_row < geo_h) &&
               ((in_row_next >= geo_h) || (gap_w > GAP_W'(lag)));
    out_col_next = out_col;
    out_row_next = out_row;
    out_addr_next = out_addr;
    if (job_push) begin
      out_addr_next = addr_inc(out_addr);
      if (out_last_col) begin
        out_col_next = '0;
        out_row_next = out_row + ROW_W'(1);
      end else begin
        out_col_next = out_col + COL_W'(1);
      end
    end
    gap_next = gap_w - GAP_W'(job_push);
    frame_done = job_push && out_last_col && (out_row + ROW_W'(1) == geo_h);
  end

  assign job_row = out_row;
  assign job_col = out_col;
  assign job_addr = out_addr;
  assign job_line_end = out_last_col;
  assign job_frame_end = out_last_col && (out_row + ROW_W'(1) == geo_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      window_size <= WINDOW_SIZE_RST;
      in_col <= '0;
      in_row <= '0;
      in_addr <= '0;
      out_col <= '0;
      out_row <= '0;
      out_addr <= '0;
      gap <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          window_size <= cfg_data[WS_W-1:0];
      endcase
      in_col <= '0;
      in_row <= '0;
      in_addr <= '0;
      out_col <= '0;
      out_row <= '0;
      out_addr <= '0;
      gap <= '0;
    end else if (frame_done) begin
      in_col <= '0;
      in_row <= '0;
      in_addr <= '0;
      out_col <= '0;
      out_row <= '0;
      out_addr <= '0;
      gap <= '0;
    end else begin
      in_col <= in_col_next;
      in_row <= in_row_next;
      in_addr <= in_addr_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      out_addr <= out_addr_next;
      gap <= gap_next;
    end
  end

  `BBC_ASSERT(a_cfg_restarts_frame, cfg_hit |=> (gap == '0 && out_row == '0 && in_row == '0), "config write did not restart the frame")
  `BBC_ASSERT(a_out_row_in_frame, out_row < geo_h, "output row ran past the frame")
  `BBC_ASSERT(a_no_accept_while_busy, back_busy |-> !accept, "word accepted while the back end reads the store")
endmodule
`default_nettype wire

>>> rtl/core/bbc_back.sv
// Back end: sums the clipped window from the line store, divides each
// channel by the window area bit by bit and saturates. Uses bbc_pkg.
`default_nettype none
`include "assert_macros.svh"
module bbc_back #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]          geo_w,
  input  wire logic [bbc_pkg::ROW_W-1:0]               geo_h,
  input  wire logic [bbc_pkg::WS_W-1:0]                geo_ws,
  input  wire logic [bbc_pkg::RAD_W-1:0]               geo_rad,
  input  wire logic                                    job_valid,
  output logic                                         job_pop,
  input  wire logic [bbc_pkg::ROW_W-1:0]               job_row,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]            job_col,
  input  wire logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0] job_addr,
  input  wire logic                                    job_line_end,
  input  wire logic                                    job_frame_end,
  output logic                                         rd_en,
  output logic [$clog2(MAX_WINDOW*MAX_WIDTH)-1:0]      rd_addr,
  input  wire bbc_pkg::pixel_t                         rd_data,
  input  wire logic                                    res_full,
  output logic                                         res_push,
  output bbc_pkg::result_t                             res,
  output logic                                         busy
);
  import bbc_pkg::*;
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int DIV_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int CNT_W = $clog2(SUM_W);
  localparam int SPAN_W = RAD_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_START, S_READ, S_DRAIN, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [AW-1:0] base, cur, row_base;
  logic le, fe, pend;
  logic [RAD_W-1:0] dr, ur, dc, uc;
  logic [SPAN_W-1:0] nrows, ncols, rcnt, ccnt;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] dcnt;
  logic [SUM_W-1:0] acc [3];
  logic [DIV_W-1:0] rem [3];
  logic [7:0] rd_ch [3];
  logic [ROW_W-1:0] rows_below;
  logic [WW-1:0] cols_right;
  logic [AW:0] off, cur_inc, base_step;

  assign rd_ch[0] = rd_data.red;
  assign rd_ch[1] = rd_data.green;
  assign rd_ch[2] = rd_data.blue;

  assign busy = (state != S_IDLE);
  assign job_pop = (state == S_IDLE) && job_valid;
  assign rd_en = (state == S_READ);
  assign rd_addr = cur;
  assign res_push = (state == S_OUT) && !res_full;

  assign rows_below = geo_h - ROW_W'(1) - row;
  assign cols_right = geo_w - WW'(1) - WW'(col);
  assign off = (AW+1)'(dr) * (AW+1)'(geo_w) + (AW+1)'(dc);
  assign cur_inc = {1'b0, cur} + (AW+1)'(1);
  assign base_step = {1'b0, row_base} + (AW+1)'(geo_w);

  always_comb begin
    res.red = (acc[0] > SUM_W'(255)) ? 8'hFF : acc[0][7:0];
    res.green = (acc[1] > SUM_W'(255)) ? 8'hFF : acc[1][7:0];
    res.blue = (acc[2] > SUM_W'(255)) ? 8'hFF : acc[2][7:0];
    res.line_end = le;
    res.frame_end = fe;
  end

  always_ff @(posedge clk) begin
    logic [DIV_W:0] sh;
    logic [AW:0] start;
    if (rst) begin
      state <= S_IDLE;
      pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            row <= job_row;
            col <= job_col;
            base <= job_addr;
            le <= job_line_end;
            fe <= job_frame_end;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          dr <= (row < ROW_W'(geo_rad)) ? RAD_W'(row) : geo_rad;
          ur <= (rows_below < ROW_W'(geo_rad)) ? RAD_W'(rows_below) : geo_rad;
          dc <= (COL_W'(col) < COL_W'(geo_rad)) ? RAD_W'(col) : geo_rad;
          uc <= (cols_right < WW'(geo_rad)) ? RAD_W'(cols_right) : geo_rad;
          dvs <= DIV_W'(geo_ws) * DIV_W'(geo_ws);
          for (int c = 0; c < 3; c++) begin
            acc[c] <= '0;
          end
          state <= S_START;
        end
        S_START: begin
          // Window origin, wrapped around the circular store.
          start = ({1'b0, base} >= off) ? ({1'b0, base} - off)
                                        : ({1'b0, base} + (AW+1)'(DEPTH) - off);
          cur <= start[AW-1:0];
          row_base <= start[AW-1:0];
          nrows <= SPAN_W'(dr) + SPAN_W'(ur);
          ncols <= SPAN_W'(dc) + SPAN_W'(uc);
          rcnt <= '0;
          ccnt <= '0;
          state <= S_READ;
        end
        S_READ: begin
          pend <= 1'b1;
          if (ccnt == ncols) begin
            if (rcnt == nrows) begin
              state <= S_DRAIN;
            end else begin
              rcnt <= rcnt + SPAN_W'(1);
              ccnt <= '0;
              row_base <= (base_step >= (AW+1)'(DEPTH)) ? AW'(base_step - (AW+1)'(DEPTH))
                                                        : base_step[AW-1:0];
              cur <= (base_step >= (AW+1)'(DEPTH)) ? AW'(base_step - (AW+1)'(DEPTH))
                                                   : base_step[AW-1:0];
            end
          end else begin
            ccnt <= ccnt + SPAN_W'(1);
            cur <= (cur_inc == (AW+1)'(DEPTH)) ? '0 : cur_inc[AW-1:0];
          end
          if (pend) begin
            for (int c = 0; c < 3; c++) begin
              acc[c] <= acc[c] + SUM_W'(rd_ch[c]);
            end
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          for (int c = 0; c < 3; c++) begin
            acc[c] <= acc[c] + SUM_W'(rd_ch[c]);
            rem[c] <= '0;
          end
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division; the quotient shifts into the sum register.
          for (int c = 0; c < 3; c++) begin
            sh = {rem[c], acc[c][SUM_W-1]};
            if (sh >= {1'b0, dvs}) begin
              rem[c] <= DIV_W'(sh - {1'b0, dvs});
              acc[c] <= {acc[c][SUM_W-2:0], 1'b1};
            end else begin
              rem[c] <= sh[DIV_W-1:0];
              acc[c] <= {acc[c][SUM_W-2:0], 1'b0};
            end
          end
          dcnt <= dcnt + CNT_W'(1);
          if (32'(dcnt) == SUM_W - 1) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BBC_ASSERT(a_pend_after_read, pend |-> ($past(state) == S_READ), "read data pending outside a store sweep")
  `BBC_ASSERT(a_div_nonzero, (state == S_DIV) |-> (dvs != '0), "division by a zero window area")
  `BBC_ASSERT_NORST(a_rst_idle, rst |=> (state == S_IDLE && !pend), "back end not idle after reset")
endmodule
`default_nettype wire

>>> rtl/core/box_blur_clamped_window.sv
// Box blur over a raster RGB stream with the window clipped at frame edges.
// A word that releases an output holds the input until its result is queued,
// also while the result queue stays full; the back end makes one store read
// per window pixel and divides each channel bit-serially. Reset is
// synchronous: geometry returns to 512 x 512 with window 3, counters clear.
`default_nettype none
module box_blur_clamped_window #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input queue side.
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              operation,
  input  wire logic [7:0]                        red_in,
  input  wire logic [7:0]                        green_in,
  input  wire logic [7:0]                        blue_in,
  // Result queue side.
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [7:0]                             red_out,
  output logic [7:0]                             green_out,
  output logic [7:0]                             blue_out,
  output logic                                   line_end,
  output logic                                   frame_end,
  // Configuration writes.
  input  wire logic                              cfg_write,
  input  wire logic [bbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bbc_pkg::*;

  // The front end writes every input pixel into a circular line store
  // addressed by raster index and decides, per word, whether the output
  // position has fallen far enough behind to be computed. Such positions
  // go as jobs through a short queue to the back end, which sweeps the
  // clipped window one store read per cycle, divides by the window area
  // and queues the saturated result. The front end holds off new words
  // while a job waits or runs, so the store never changes under a sweep.
  // The line store needs no clearing pass: every entry a window reads was
  // written earlier in the same frame.
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int JOB_W = ROW_W + COL_W + AW + 2;
  localparam int RES_W = $bits(result_t);

  pixel_t pix_in;
  pixel_t wr_data, rd_data;
  logic wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  logic [WW-1:0] geo_w;
  logic [ROW_W-1:0] geo_h;
  logic [WS_W-1:0] geo_ws;
  logic [RAD_W-1:0] geo_rad;

  logic job_push, job_full, job_empty, job_pop, back_busy;
  logic [ROW_W-1:0] f_row, b_row;
  logic [COL_W-1:0] f_col, b_col;
  logic [AW-1:0] f_addr, b_addr;
  logic f_le, f_fe, b_le, b_fe;
  logic [JOB_W-1:0] job_din, job_dout;

  logic res_push, res_full;
  result_t res_in, res_head;
  logic [RES_W-1:0] res_dout;

  assign pix_in = '{red: red_in, green: green_in, blue: blue_in};

  bbc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk, .rst, .push, .full, .operation,
    .pix(pix_in),
    .cfg_write, .cfg_index, .cfg_data,
    .job_empty, .back_busy, .job_push,
    .job_row(f_row), .job_col(f_col), .job_addr(f_addr),
    .job_line_end(f_le), .job_frame_end(f_fe),
    .wr_en, .wr_addr, .wr_data,
    .geo_w, .geo_h, .geo_ws, .geo_rad
  );

  // The job queue is only ever pushed while empty; its full flag is moot.
  assign job_din = {f_row, f_col, f_addr, f_le, f_fe};
  assign {b_row, b_col, b_addr, b_le, b_fe} = job_dout;

  bbc_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_job_q (
    .clk, .rst,
    .push(job_push), .din(job_din), .full(job_full),
    .pop(job_pop), .dout(job_dout), .empty(job_empty)
  );

  bbc_store #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data
  );

  bbc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk, .rst, .geo_w, .geo_h, .geo_ws, .geo_rad,
    .job_valid(!job_empty && !job_full || !job_empty), .job_pop,
    .job_row(b_row), .job_col(b_col), .job_addr(b_addr),
    .job_line_end(b_le), .job_frame_end(b_fe),
    .rd_en, .rd_addr, .rd_data,
    .res_full, .res_push, .res(res_in),
    .busy(back_busy)
  );

  // Result queue: finished words wait here so the back end can move on.
  bbc_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk, .rst,
    .push(res_push), .din(res_in), .full(res_full),
    .pop, .dout(res_dout), .empty
  );

  assign res_head = res_dout;
  assign red_out = res_head.red;
  assign green_out = res_head.green;
  assign blue_out = res_head.blue;
  assign line_end = res_head.line_end;
  assign frame_end = res_head.frame_end;
endmodule
`default_nettype wire

>>> sim/blur_checker.sv
// Checker for the box blur core: watches the input, result and register
// write ports, predicts every result word, and compares. Depends on bbc_pkg.
module blur_checker #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_WINDOW = 15
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           full,
  input  logic                           operation,
  input  logic [7:0]                     red_in,
  input  logic [7:0]                     green_in,
  input  logic [7:0]                     blue_in,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [7:0]                     red_out,
  input  logic [7:0]                     green_out,
  input  logic [7:0]                     blue_out,
  input  logic                           line_end,
  input  logic                           frame_end,
  input  logic                           cfg_write,
  input  logic [bbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  import bbc_pkg::*;

  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;

  bbc_pkg::pixel_t  pix_store [DEPTH];
  bbc_pkg::result_t blurred_words [$];
  int unsigned col_in, row_in, col_out, row_out;
  logic [9:0] width_reg, height_reg;
  logic [3:0] window_reg;

  assign pending = blurred_words.size();

  task automatic restart_frame();
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
  endtask

  // One accepted word: store a frame pixel, then emit the pixel that is now
  // far enough behind the input for its whole window to be present.
  task automatic blur_step(input logic op, input pixel_t px, output logic got,
                           output result_t res);
    int unsigned w, h, ws, rad, lag, pin, pout, r0, r1, c0, c1, sr, sg, sb, dv;
    pixel_t v;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (height_reg == 0) ? 1 : height_reg;
    ws = (window_reg == 0) ? 1 : window_reg;
    if (ws > MAX_WINDOW) ws = MAX_WINDOW;
    rad = ws / 2;
    if (rad > (MAX_WINDOW - 1) / 2) rad = (MAX_WINDOW - 1) / 2;
    lag = rad * w + rad;
    got = 1'b0;
    res = '0;
    if (op == OP_PIXEL && row_in < h) begin
      pix_store[(row_in * w + col_in) % DEPTH] = px;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
    end
    if (row_out >= h) return;
    pin = row_in * w + col_in;
    pout = row_out * w + col_out;
    if (!(row_in >= h || (pin > pout && pin - pout > lag))) return;
    r0 = (row_out > rad) ? row_out - rad : 0;
    r1 = (row_out + rad < h) ? row_out + rad : h - 1;
    c0 = (col_out > rad) ? col_out - rad : 0;
    c1 = (col_out + rad < w) ? col_out + rad : w - 1;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int unsigned x = r0; x <= r1; x++) begin
      for (int unsigned y = c0; y <= c1; y++) begin
        v = pix_store[(x * w + y) % DEPTH];
        sr += v.red;
        sg += v.green;
        sb += v.blue;
      end
    end
    dv = ws * ws;
    res.red = (sr / dv > 255) ? 8'd255 : 8'(sr / dv);
    res.green = (sg / dv > 255) ? 8'd255 : 8'(sg / dv);
    res.blue = (sb / dv > 255) ? 8'd255 : 8'(sb / dv);
    res.line_end = (col_out == w - 1);
    res.frame_end = (col_out == w - 1) && (row_out == h - 1);
    got = 1'b1;
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
    if (row_out >= h) restart_frame();
  endtask

  always @(posedge clk) begin
    logic got;
    result_t want, seen;
    pixel_t px;
    if (rst) begin
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      window_reg = WINDOW_SIZE_RST;
      restart_frame();
      blurred_words.delete();
      errors <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data;
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
            restart_frame();
          end
          REG_WINDOW_SIZE: begin
            window_reg = cfg_data[3:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (push && !full) begin
        px = '{red: red_in, green: green_in, blue: blue_in};
        blur_step(operation, px, got, want);
        if (got) blurred_words.push_back(want);
      end
      if (pop && !empty) begin
        seen = '{red: red_out, green: green_out, blue: blue_out,
                 line_end: line_end, frame_end: frame_end};
        if (blurred_words.size() == 0) begin
          $display("%0t: result word with none expected: %h", $time, seen);
          errors <= errors + 1;
        end else begin
          want = blurred_words.pop_front();
          if (want !== seen) begin
            $display("%0t: mismatch expected r=%0d g=%0d b=%0d le=%0b fe=%0b",
                     $time, want.red, want.green, want.blue, want.line_end,
                     want.frame_end);
            $display("%0t:          actual   r=%0d g=%0d b=%0d le=%0b fe=%0b",
                     $time, seen.red, seen.green, seen.blue, seen.line_end,
                     seen.frame_end);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> sim/testbench.sv
// Top of the box blur testbench: clock, reset, register writes, pixel
// stimulus and the verdict. Depends on bbc_pkg, blur_checker and the core.
module testbench;
  import bbc_pkg::*;

  // Index that decodes to no register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Idle wait that outlasts the longest time a word may occupy the core.
  localparam int SETTLE = 400;
  localparam int LIMIT = 4000000;
  localparam int WORD_BUDGET = 1650;

  logic clk, rst;
  logic push, full, operation, empty, pop, line_end, frame_end, cfg_write;
  logic [7:0] red_in, green_in, blue_in, red_out, green_out, blue_out;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending, cycles, burst_left, stall_mode, stall_left;
  int unsigned width_eff, height_eff, window_eff, words_sent;

  box_blur_clamped_window dut (.*);

  blur_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // The receiver switches among always ready, coin-flip stalls and long
  // stalls, so backpressure lands on every phase of the core's work.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Sends one word; the sender runs in bursts with random gaps between them.
  task automatic send_word(input logic op, input logic [7:0] r, g, b);
    @(negedge clk);
    if (burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    push = 1'b1;
    operation = op;
    red_in = r;
    green_in = g;
    blue_in = b;
    burst_left--;
    words_sent++;
    do @(posedge clk); while (full);
  endtask

  // Register writes happen only once every expected word is out and the
  // core has had time to finish any word that yields no result.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_FRAME_WIDTH: width_eff = (val == 0) ? 1 : (val > 512 ? 512 : val);
      REG_FRAME_HEIGHT: height_eff = (val == 0) ? 1 : val;
      REG_WINDOW_SIZE: window_eff = (val[3:0] == 0) ? 1 : val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int w, h, ws);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(ws));
  endtask

  // Channel values: mostly random, sometimes the extremes, 55h or AAh, or a flat
  // frame of full white so that even windows saturate.
  function automatic logic [7:0] chan(input int style);
    case (style)
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: return 8'hFF;
      default: return $urandom_range(0, 1) ? 8'h55 : 8'hAA;
    endcase
  endfunction

  // One frame of pixels with stray drain ticks mixed in (they do nothing
  // before the input is complete), then, for a whole frame, enough drain ticks
  // to flush the pixels still behind the window; a partial frame stops early.
  // Surplus pixels during the flush are dropped by the core, unless the frame
  // is already out and they would start a new one.
  task automatic run_frame(input int style, input int frac_pixels);
    int unsigned total, lag, rad, flush;
    total = width_eff * height_eff;
    if (frac_pixels > 0) total = (total * frac_pixels) / 100;
    rad = window_eff / 2;
    lag = rad * width_eff + rad;
    flush = (lag < total) ? lag : total;
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(0, 15) == 0) send_word(OP_DRAIN, chan(0), chan(0), chan(0));
      send_word(OP_PIXEL, chan(style), chan(style), chan(style));
    end
    if (frac_pixels > 0) return;
    for (int unsigned i = 0; i <= flush; i++) begin
      if (lag > 0 && $urandom_range(0, 4) == 0)
        send_word(OP_PIXEL, chan(0), chan(0), chan(0));
      else
        send_word(OP_DRAIN, chan(0), chan(0), chan(0));
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    operation = OP_PIXEL;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    burst_left = 0;
    words_sent = 0;
    width_eff = 512;
    height_eff = 512;
    window_eff = 3;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: extremes of the channels and of every register.
    set_geometry(4, 3, 3);
    send_word(OP_DRAIN, 8'h00, 8'h00, 8'h00);
    run_frame(1, 0);
    run_frame(3, 0);
    write_reg(REG_WINDOW_SIZE, 1);
    run_frame(0, 0);
    set_geometry(5, 4, 15);
    run_frame(2, 0);
    set_geometry(3, 3, 2);
    run_frame(2, 0);
    set_geometry(0, 0, 0);
    run_frame(1, 0);
    write_reg(REG_UNUSED, 10'h3FF);
    run_frame(1, 0);
    set_geometry(1023, 1, 15);
    run_frame(0, 0);
    set_geometry(1, 24, 4);
    run_frame(0, 0);
    // A register write in the middle of a frame starts a new one.
    set_geometry(6, 5, 5);
    run_frame(0, 50);

    // Random part: small frames under random geometry, a few frames per
    // setting, now and then cut short by the next register write.
    while (words_sent < WORD_BUDGET) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(1, 16)));
        1: write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 12)));
        2: write_reg(REG_WINDOW_SIZE, CFG_DATA_W'($urandom_range(0, 15)));
        default: write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 1023)));
      endcase
      repeat ($urandom_range(1, 3)) begin
        run_frame($urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0,
                  $urandom_range(0, 7) == 0 ? $urandom_range(10, 90) : 0);
      end
    end

    @(negedge clk);
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
